// ----- hw/rtl/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the comment stripper
// Character codes, lexer modes and the structs passed between the lexer, the
// result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  // Width of one text character (UTF-16 code unit).
  localparam int CHAR_W = 16;

  // Characters the lexer reacts to.
  localparam logic [CHAR_W-1:0] CH_NL     = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_APOS   = 16'h0027;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0022;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Lexer modes.
  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_STR   = 3'd1,
    MODE_CHR   = 3'd2,
    MODE_LINE  = 3'd3,
    MODE_BLOCK = 3'd4
  } lex_mode_t;

  // Results produced by one character: count and up to two characters.
  typedef struct packed {
    logic [1:0]        num;
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
  } lex_res_t;

  // One entry of the result queue.
  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              run_end;
  } q_entry_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ccs_ifs.sv -----
// ----------------------------------------------------------------------------
// ccs_ifs: valid/ready channels of the comment stripper
// One interface for source text characters and one for kept characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_in_if;
  logic                        valid;
  logic                        ready;
  logic [ccs_pkg::CHAR_W-1:0]  in_char;
  logic                        text_last;

  modport source (output valid, output in_char, output text_last, input ready);
  modport sink   (input valid, input in_char, input text_last, output ready);
endinterface

interface ccs_out_if;
  logic                        valid;
  logic                        ready;
  logic [ccs_pkg::CHAR_W-1:0]  out_char;
  logic                        run_end;

  modport source (output valid, output out_char, output run_end, input ready);
  modport sink   (input valid, input out_char, input run_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ccs_lexer.sv -----
// ----------------------------------------------------------------------------
// ccs_lexer: lexical state machine of the comment stripper
// Takes one registered character per cycle, updates the lexer state and
// reports the zero, one or two characters that are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_lexer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       chr_vld,
  input  wire logic [ccs_pkg::CHAR_W-1:0] chr,
  input  wire logic                       chr_last,
  output ccs_pkg::lex_res_t               res
);

  ccs_pkg::lex_mode_t mode_r, mode_nxt;
  logic esc_r, esc_nxt;
  logic slash_r, slash_nxt;
  logic star_r, star_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ccs_pkg::MODE_CODE;
      esc_r   <= 1'b0;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
    end else if (chr_vld) begin
      mode_r  <= mode_nxt;
      esc_r   <= esc_nxt;
      slash_r <= slash_nxt;
      star_r  <= star_nxt;
    end
  end

  // Next state and kept characters.
  always_comb begin
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    slash_nxt = slash_r;
    star_nxt  = star_r;
    res.num   = 2'd0;
    res.c0    = chr;
    res.c1    = chr;

    case (mode_r)
      ccs_pkg::MODE_STR, ccs_pkg::MODE_CHR: begin
        res.num = 2'd1;
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (chr == ccs_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (mode_r == ccs_pkg::MODE_STR && chr == ccs_pkg::CH_QUOTE) begin
          mode_nxt = ccs_pkg::MODE_CODE;
        end else if (mode_r == ccs_pkg::MODE_CHR && chr == ccs_pkg::CH_APOS) begin
          mode_nxt = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (chr == ccs_pkg::CH_NL) begin
          res.num  = 2'd1;
          mode_nxt = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (star_r && chr == ccs_pkg::CH_SLASH) begin
          star_nxt = 1'b0;
          mode_nxt = ccs_pkg::MODE_CODE;
        end else begin
          star_nxt = (chr == ccs_pkg::CH_STAR);
          if (chr == ccs_pkg::CH_NL) begin
            res.num = 2'd1;
          end
        end
      end
      default: begin
        // Code mode; unused mode codes behave the same way.
        mode_nxt = ccs_pkg::MODE_CODE;
        esc_nxt  = 1'b0;
        if (slash_r) begin
          slash_nxt = 1'b0;
          if (chr == ccs_pkg::CH_SLASH) begin
            mode_nxt = ccs_pkg::MODE_LINE;
          end else if (chr == ccs_pkg::CH_STAR) begin
            mode_nxt = ccs_pkg::MODE_BLOCK;
            star_nxt = 1'b0;
          end else begin
            // The held slash goes out first, then this character.
            res.num = 2'd2;
            res.c0  = ccs_pkg::CH_SLASH;
            if (chr == ccs_pkg::CH_QUOTE) begin
              mode_nxt = ccs_pkg::MODE_STR;
            end else if (chr == ccs_pkg::CH_APOS) begin
              mode_nxt = ccs_pkg::MODE_CHR;
            end
          end
        end else if (chr == ccs_pkg::CH_SLASH) begin
          if (chr_last) begin
            res.num = 2'd1;
          end else begin
            slash_nxt = 1'b1;
          end
        end else begin
          res.num = 2'd1;
          if (chr == ccs_pkg::CH_QUOTE) begin
            mode_nxt = ccs_pkg::MODE_STR;
          end else if (chr == ccs_pkg::CH_APOS) begin
            mode_nxt = ccs_pkg::MODE_CHR;
          end
        end
      end
    endcase

    // End of text: everything returns to its reset value.
    if (chr_last) begin
      mode_nxt  = ccs_pkg::MODE_CODE;
      esc_nxt   = 1'b0;
      slash_nxt = 1'b0;
      star_nxt  = 1'b0;
    end

    if (!chr_vld) begin
      res.num = 2'd0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ccs_out_queue.sv -----
// ----------------------------------------------------------------------------
// ccs_out_queue: result queue of the comment stripper
// Small queue that takes up to two kept characters per cycle and hands one
// per transfer to the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_out_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  ccs_pkg::lex_res_t               push,
  input  wire logic                       pop,
  output ccs_pkg::q_entry_t               head,
  output ccs_pkg::q_stat_t                stat
);

  ccs_pkg::q_entry_t mem [ccs_pkg::QDEPTH];

  logic [ccs_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ccs_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ccs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [ccs_pkg::PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + {{(ccs_pkg::PTR_W-1){1'b0}}, 1'b1};

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ccs_pkg::PTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + {{(ccs_pkg::PTR_W-1){1'b0}}, pop};
    count_nxt  = count_r + ccs_pkg::CNT_W'(push.num)
               - {{(ccs_pkg::CNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; the last character of an input carries run_end.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr_r].chr     <= push.c0;
      mem[wr_ptr_r].run_end <= (push.num == 2'd1);
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_p1].chr     <= push.c1;
      mem[wr_ptr_p1].run_end <= 1'b1;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign stat.count = count_r;

endmodule

`default_nettype wire

// ----- hw/rtl/cpp_comment_stripper_unit.sv -----
// ----------------------------------------------------------------------------
// cpp_comment_stripper_unit: C/C++ comment removal on a character stream
// Drops line and block comments, keeps their newlines, and leaves comment
// markers inside string and character literals alone.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while the result queue has
// room. A character first sits in the input register, where the lexer decides
// what it keeps, and its results then wait in a four-entry result queue. Most
// characters give zero or one result; a slash held back and followed by an
// ordinary character gives two, and those take two output transfers. Input
// ready is set by the space left in the result queue: the queue must have
// room for two results of the character in the input register plus two for
// the new one, after the current output transfer. run_end marks the last
// result that a character produced, and the lexer returns to code mode after
// the character flagged text_last.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_comment_stripper_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ccs_in_if.sink    in_ch,
  ccs_out_if.source out_ch
);

  logic                       stg_vld_r;
  logic [ccs_pkg::CHAR_W-1:0] stg_chr_r;
  logic                       stg_last_r;
  logic                       in_xfer;
  logic                       out_xfer;
  logic [ccs_pkg::CNT_W-1:0]  occ;
  logic [ccs_pkg::CNT_W-1:0]  resv;
  ccs_pkg::lex_res_t          res;
  ccs_pkg::q_entry_t          head;
  ccs_pkg::q_stat_t           stat;

  // Handshakes and queue space check.
  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign occ         = stat.count - {{(ccs_pkg::CNT_W-1){1'b0}}, out_xfer};
  assign resv        = stg_vld_r ? ccs_pkg::CNT_W'(2) : '0;
  assign in_ch.ready = (occ + resv) <= ccs_pkg::CNT_W'(ccs_pkg::QDEPTH - 2);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_chr_r  <= in_ch.in_char;
      stg_last_r <= in_ch.text_last;
    end
  end

  ccs_lexer u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .chr_vld  (stg_vld_r),
    .chr      (stg_chr_r),
    .chr_last (stg_last_r),
    .res      (res)
  );

  ccs_out_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res),
    .pop   (out_xfer),
    .head  (head),
    .stat  (stat)
  );

  // Result channel.
  assign out_ch.valid    = (stat.count != '0);
  assign out_ch.out_char = head.chr;
  assign out_ch.run_end  = head.run_end;

  // The queue never holds more entries than it has.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= ccs_pkg::CNT_W'(ccs_pkg::QDEPTH))
    else $error("result queue count above depth");

  // Results of the registered character always find room in the queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (res.num != 2'd0) |->
      ((occ + ccs_pkg::CNT_W'(res.num)) <= ccs_pkg::CNT_W'(ccs_pkg::QDEPTH)))
    else $error("result queue overflow");

  // A transfer on the input channel fills the input register next cycle.
  a_stage_fill : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> stg_vld_r)
    else $error("input register not loaded after transfer");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the C/C++ comment stripper
// Directed texts cover slashes, comments of both kinds and literals with
// escapes. Random C-like texts follow, with idle bursts on both channels, one
// long output hold-off and a final stretch without idling. A behavioral lexer
// predicts every kept character, and a monitor compares each output transfer
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  // The longest correct pause without a transfer is the output hold-off below,
  // so this limit leaves a wide margin.
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;

  ccs_in_if  in_if ();
  ccs_out_if out_if ();

  cpp_comment_stripper_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Lexer state of the predictor.
  ccs_pkg::lex_mode_t lex_mode;
  logic               esc_pend;
  logic               slash_held;
  logic               star_seen;

  // Predicted kept characters, oldest first, and the text being sent.
  ccs_pkg::q_entry_t          kept_q[$];
  logic [ccs_pkg::CHAR_W-1:0] text_buf[$];

  int errors;
  int chars_sent;
  int idle_cycles;
  int stall_left;
  int hold_left;
  bit send_gaps;
  bit recv_stalls;
  bit hold_req;

  always #1 clk = ~clk;

  // Returns the lexer to code mode with nothing pending.
  function automatic void reset_lexer();
    lex_mode   = ccs_pkg::MODE_CODE;
    esc_pend   = 1'b0;
    slash_held = 1'b0;
    star_seen  = 1'b0;
  endfunction

  // Works out the characters kept for one accepted input character.
  function automatic void predict_kept(input logic [ccs_pkg::CHAR_W-1:0] c,
                                       input logic last);
    logic [ccs_pkg::CHAR_W-1:0] res [2];
    int                         n;
    ccs_pkg::q_entry_t          e;
    n = 0;
    case (lex_mode)
      ccs_pkg::MODE_STR, ccs_pkg::MODE_CHR: begin
        res[n] = c;
        n++;
        if (esc_pend) begin
          esc_pend = 1'b0;
        end else if (c == ccs_pkg::CH_BSLASH) begin
          esc_pend = 1'b1;
        end else if (lex_mode == ccs_pkg::MODE_STR && c == ccs_pkg::CH_QUOTE) begin
          lex_mode = ccs_pkg::MODE_CODE;
        end else if (lex_mode == ccs_pkg::MODE_CHR && c == ccs_pkg::CH_APOS) begin
          lex_mode = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (c == ccs_pkg::CH_NL) begin
          res[n] = c;
          n++;
          lex_mode = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (star_seen && c == ccs_pkg::CH_SLASH) begin
          star_seen = 1'b0;
          lex_mode  = ccs_pkg::MODE_CODE;
        end else begin
          star_seen = (c == ccs_pkg::CH_STAR);
          if (c == ccs_pkg::CH_NL) begin
            res[n] = c;
            n++;
          end
        end
      end
      default: begin
        lex_mode = ccs_pkg::MODE_CODE;
        esc_pend = 1'b0;
        if (slash_held && (c == ccs_pkg::CH_SLASH || c == ccs_pkg::CH_STAR)) begin
          // A held slash and its successor open a comment; both are dropped.
          slash_held = 1'b0;
          star_seen  = 1'b0;
          lex_mode   = (c == ccs_pkg::CH_SLASH) ? ccs_pkg::MODE_LINE
                                                : ccs_pkg::MODE_BLOCK;
        end else if (!slash_held && c == ccs_pkg::CH_SLASH && !last) begin
          slash_held = 1'b1;
        end else begin
          // A held slash goes out just before the character that follows it.
          if (slash_held) begin
            res[n] = ccs_pkg::CH_SLASH;
            n++;
          end
          slash_held = 1'b0;
          res[n] = c;
          n++;
          if (c == ccs_pkg::CH_QUOTE) begin
            lex_mode = ccs_pkg::MODE_STR;
          end else if (c == ccs_pkg::CH_APOS) begin
            lex_mode = ccs_pkg::MODE_CHR;
          end
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      e.chr     = res[i];
      e.run_end = (i == n - 1);
      kept_q.push_back(e);
    end
    if (last) begin
      reset_lexer();
    end
  endfunction

  function automatic logic [ccs_pkg::CHAR_W-1:0] letter();
    return ccs_pkg::CHAR_W'(16'h0061 + $urandom_range(0, 25));
  endfunction

  // Mostly characters the lexer reacts to, often any 16-bit code unit.
  function automatic logic [ccs_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0: return ccs_pkg::CH_SLASH;
      1: return ccs_pkg::CH_STAR;
      2: return ccs_pkg::CH_NL;
      3: return ccs_pkg::CH_BSLASH;
      4: return ccs_pkg::CH_APOS;
      5: return ccs_pkg::CH_QUOTE;
      6, 7: return letter();
      default: return ccs_pkg::CHAR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Appends one source construct with random content to the text buffer.
  // Literals and block comments are sometimes left unterminated.
  function automatic void add_piece(input int kind);
    int len;
    len = $urandom_range(0, 6);
    case (kind)
      0: begin
        repeat (len + 1) text_buf.push_back(letter());
      end
      1: begin
        text_buf.push_back(ccs_pkg::CH_QUOTE);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) text_buf.push_back(ccs_pkg::CH_BSLASH);
          text_buf.push_back(pick_char());
        end
        if ($urandom_range(0, 4) != 0) text_buf.push_back(ccs_pkg::CH_QUOTE);
      end
      2: begin
        text_buf.push_back(ccs_pkg::CH_APOS);
        if ($urandom_range(0, 1) == 0) text_buf.push_back(ccs_pkg::CH_BSLASH);
        text_buf.push_back(pick_char());
        text_buf.push_back(ccs_pkg::CH_APOS);
      end
      3: begin
        text_buf.push_back(ccs_pkg::CH_SLASH);
        text_buf.push_back(ccs_pkg::CH_SLASH);
        repeat (len) text_buf.push_back(pick_char());
        text_buf.push_back(ccs_pkg::CH_NL);
      end
      4: begin
        text_buf.push_back(ccs_pkg::CH_SLASH);
        text_buf.push_back(ccs_pkg::CH_STAR);
        repeat (len) text_buf.push_back(pick_char());
        if ($urandom_range(0, 5) != 0) begin
          text_buf.push_back(ccs_pkg::CH_STAR);
          text_buf.push_back(ccs_pkg::CH_SLASH);
        end
      end
      5: begin
        text_buf.push_back(letter());
        text_buf.push_back(ccs_pkg::CH_SLASH);
        text_buf.push_back(letter());
      end
      default: begin
        repeat (len / 2 + 1) text_buf.push_back(pick_char());
      end
    endcase
  endfunction

  // Offers one character and waits for its transfer. Called and left at a
  // falling edge; valid stays high so the next call can follow directly.
  task automatic send_char(input logic [ccs_pkg::CHAR_W-1:0] c, input logic last);
    int gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_char   <= c;
    in_if.text_last <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_kept(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  // Sends the buffer as one text, flagging its final character.
  task automatic send_buffer();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // Stops offering input until every predicted character has arrived.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (kept_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Held slash before an extreme code unit, the zero code unit, and a slash
  // on the final character, which goes out at once.
  task automatic test_slash_handling();
    text_buf = {ccs_pkg::CH_SLASH, 16'hFFFF, 16'h0000, ccs_pkg::CH_SLASH};
    send_buffer();
  endtask

  // Line comment ended by its newline, then a block comment whose opening
  // star must not close it, with a kept newline inside.
  task automatic test_comments();
    text_buf = {ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, ccs_pkg::CH_NL,
                ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH,
                ccs_pkg::CH_NL, ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH, 16'h0078};
    send_buffer();
  endtask

  // Comment markers and an escaped quote inside a string, then an escaped
  // apostrophe inside a character literal.
  task automatic test_literals();
    text_buf = {ccs_pkg::CH_QUOTE, ccs_pkg::CH_BSLASH, ccs_pkg::CH_QUOTE,
                ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, ccs_pkg::CH_QUOTE,
                ccs_pkg::CH_APOS, ccs_pkg::CH_BSLASH, ccs_pkg::CH_APOS,
                ccs_pkg::CH_APOS};
    send_buffer();
  endtask

  // A text that ends inside a block comment; the next text starts in code.
  task automatic test_abandoned_text();
    text_buf = {ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR};
    send_buffer();
    text_buf = {ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH};
    send_buffer();
  endtask

  // Random texts built from C constructs, with idling switched per text.
  task automatic test_random_text(input int count, input bit with_idle);
    int target;
    int pieces;
    target = chars_sent + count;
    while (chars_sent < target) begin
      send_gaps   = with_idle && ($urandom_range(0, 3) != 0);
      recv_stalls = with_idle && ($urandom_range(0, 3) != 0);
      pieces = $urandom_range(1, 6);
      repeat (pieces) add_piece($urandom_range(0, 6));
      send_buffer();
    end
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
  endtask

  // Long output hold-off while slash pairs that give two results each keep
  // coming, so the result queue fills and input ready drops.
  task automatic test_backpressure();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    hold_req    = 1'b1;
    repeat (20) begin
      text_buf.push_back(ccs_pkg::CH_SLASH);
      text_buf.push_back(letter());
    end
    send_buffer();
    wait_drained();
  endtask

  // Output ready: a requested long hold-off, random stall bursts, else high.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (recv_stalls && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Each output transfer is checked against the oldest predicted character.
  always @(posedge clk) begin
    ccs_pkg::q_entry_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (kept_q.size() == 0) begin
        $error("out_char: expected none, got %h", out_if.out_char);
        errors++;
      end else begin
        want = kept_q.pop_front();
        if (out_if.out_char !== want.chr) begin
          $error("out_char: expected %h, got %h", want.chr, out_if.out_char);
          errors++;
        end
        if (out_if.run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, out_if.run_end);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.in_char   = '0;
    in_if.text_last = 1'b0;
    out_if.ready    = 1'b0;
    errors          = 0;
    chars_sent      = 0;
    idle_cycles     = 0;
    stall_left      = 0;
    hold_left       = 0;
    send_gaps       = 1'b0;
    recv_stalls     = 1'b0;
    hold_req        = 1'b0;
    reset_lexer();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_slash_handling();
    test_comments();
    test_literals();
    test_abandoned_text();
    test_random_text(640, 1'b1);
    test_backpressure();
    test_random_text(350, 1'b0);
    wait_drained();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ccs_pkg.sv
hw/rtl/ccs_ifs.sv
hw/rtl/ccs_lexer.sv
hw/rtl/ccs_out_queue.sv
hw/rtl/cpp_comment_stripper_unit.sv
bench/tb.sv
